@@ src/sbd_pkg.sv @@
package sbd_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int SECTOR_COUNT = 16384;

    localparam int OFS_W  = 12;
    localparam int SIZE_W = 4;
    localparam int DATA_W = 64;
    localparam int IN_TDATA_W = OFS_W + SIZE_W + DATA_W;

    localparam int WIN_WORDS   = SECTOR_BYTES / 8;
    localparam int WIN_AW      = $clog2(WIN_WORDS);
    localparam int POS_W       = $clog2(SECTOR_BYTES);
    localparam int SECT_W      = $clog2(SECTOR_COUNT);
    localparam int STORE_WORDS = SECTOR_COUNT * WIN_WORDS;
    localparam int MAP_ROWS    = SECTOR_COUNT / 64;
    localparam int MAP_AW      = $clog2(MAP_ROWS);

    localparam logic [OFS_W-1:0] OFS_SECTOR  = 12'h000;
    localparam logic [OFS_W-1:0] OFS_COMMAND = 12'h008;
    localparam logic [OFS_W-1:0] OFS_STATUS  = 12'h00c;
    localparam logic [OFS_W-1:0] OFS_WINDOW  = 12'h100;

    localparam logic [31:0] CMD_LOAD_SECTOR = 32'd1;
    localparam logic [31:0] CMD_SAVE_SECTOR = 32'd2;

    localparam logic [2:0] K_FAULT   = 3'd0;
    localparam logic [2:0] K_RD_SECT = 3'd1;
    localparam logic [2:0] K_RD_STAT = 3'd2;
    localparam logic [2:0] K_WR_SECT = 3'd3;
    localparam logic [2:0] K_CMD     = 3'd4;
    localparam logic [2:0] K_WIN_RD  = 3'd5;
    localparam logic [2:0] K_WIN_WR  = 3'd6;

    typedef struct packed {
        logic [2:0]        kind;
        logic [POS_W-1:0]  pos;
        logic [7:0]        bmask;
        logic              need_hi;
        logic [DATA_W-1:0] wdata;
    } req_t;

endpackage

@@ src/sbd_ram.sv @@
module sbd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/sbd_decode.sv @@
module sbd_decode import sbd_pkg::*; (
    input  logic              mode,
    input  logic [OFS_W-1:0]  offset,
    input  logic [SIZE_W-1:0] access_bytes,
    input  logic [DATA_W-1:0] write_data,
    output req_t              req
);

    logic             size_ok;
    logic             win_ok;
    logic [OFS_W-1:0] rel;
    logic [OFS_W:0]   end_pos;
    logic [4:0]       lane_end;

    always_comb
    begin
        size_ok  = (access_bytes == 4'd1) || (access_bytes == 4'd2) ||
                   (access_bytes == 4'd4) || (access_bytes == 4'd8);
        rel      = offset - OFS_WINDOW;
        end_pos  = {1'b0, rel} + (OFS_W + 1)'(access_bytes);
        win_ok   = (offset >= OFS_WINDOW) && (end_pos <= (OFS_W + 1)'(SECTOR_BYTES));
        lane_end = {2'b00, rel[2:0]} + {1'b0, access_bytes};

        req.pos     = rel[POS_W-1:0];
        req.need_hi = lane_end > 5'd8;
        req.wdata   = write_data;

        case (access_bytes)
            4'd1:    req.bmask = 8'h01;
            4'd2:    req.bmask = 8'h03;
            4'd4:    req.bmask = 8'h0f;
            4'd8:    req.bmask = 8'hff;
            default: req.bmask = 8'h00;
        endcase

        req.kind = K_FAULT;
        if (size_ok)
        begin
            if (mode)
            begin
                if (offset == OFS_SECTOR && access_bytes == 4'd8)
                    req.kind = K_WR_SECT;
                else if (offset == OFS_COMMAND && access_bytes == 4'd4)
                    req.kind = K_CMD;
                else if (win_ok)
                    req.kind = K_WIN_WR;
            end
            else
            begin
                if (offset == OFS_SECTOR && access_bytes == 4'd8)
                    req.kind = K_RD_SECT;
                else if (offset == OFS_STATUS && access_bytes == 4'd4)
                    req.kind = K_RD_STAT;
                else if (win_ok)
                    req.kind = K_WIN_RD;
            end
        end
    end

endmodule

@@ src/sector_block_device_registers_unit.sv @@
// Memory-mapped sector disk. Each transaction on the slave stream is one bus
// access: tuser carries the load/store selector, tdata the offset, the size
// and the store data. Each access yields exactly one transaction on the master
// stream with the load data in tdata and the access fault flag in tuser.
// Register accesses and faults go through an execute and a response state.
// Window accesses also read the addressed word and the next, and a store that
// crosses a word boundary writes its high word in a state of its own, since
// the window is a 64-bit memory read one word per cycle with a
// read-modify-write for stores. The next access is taken in the idle state.
// A sector command copies 64 words between the window memory and the storage
// memory, one word per cycle, read from one memory and written to the other;
// that copy loop sets the throughput of command traffic.
// A rejected command, or a load of a sector never saved, skips the copy.
// The block works on one access at a time and takes the next one while the
// previous result still waits in the output register.
// After reset the block clears all 256 rows of the sector-written map and
// accepts nothing in that time; the window is cleared at once by its valid
// bits. When the receiver stalls, the finished result holds in the output
// register and the next access waits before delivery until the register frees.
module sector_block_device_registers_unit import sbd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: offset, access_bytes, write_data.
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    // Fields from bit 0: mode.
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: read_data.
    output logic [DATA_W-1:0]     m_axis_tdata,
    // Fields from bit 0: fault.
    output logic [0:0]            m_axis_tuser
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_EXEC = 4'd2;
    localparam logic [3:0] S_MAP  = 4'd3;
    localparam logic [3:0] S_LOAD = 4'd4;
    localparam logic [3:0] S_SAVE = 4'd5;
    localparam logic [3:0] S_W0   = 4'd6;
    localparam logic [3:0] S_W1   = 4'd7;
    localparam logic [3:0] S_WHI  = 4'd8;
    localparam logic [3:0] S_RESP = 4'd9;

    req_t dec_req;

    logic [3:0]           state_reg, state_next;
    req_t                 req_reg, req_next;
    logic [DATA_W-1:0]    sector_reg, sector_next;
    logic                 err_reg, err_next;
    logic [WIN_WORDS-1:0] win_vld_reg, win_vld_next;
    logic [WIN_AW:0]      cnt_reg, cnt_next;
    logic [MAP_AW-1:0]    clr_reg, clr_next;
    logic [DATA_W-1:0]    lo_reg, lo_next;
    logic [DATA_W-1:0]    hi_reg, hi_next;
    logic [63:0]          map_row_reg, map_row_next;
    logic [DATA_W-1:0]    res_data_reg, res_data_next;
    logic                 res_fault_reg, res_fault_next;
    logic                 out_vld_reg, out_vld_next;
    logic [DATA_W-1:0]    out_data_reg, out_data_next;
    logic                 out_fault_reg, out_fault_next;

    logic                 win_we;
    logic [WIN_AW-1:0]    win_waddr, win_raddr;
    logic [DATA_W-1:0]    win_wdata, win_q;
    logic                 st_we;
    logic [SECT_W+WIN_AW-1:0] st_waddr, st_raddr;
    logic [DATA_W-1:0]    st_wdata, st_q;
    logic                 map_we;
    logic [MAP_AW-1:0]    map_waddr, map_raddr;
    logic [63:0]          map_wdata, map_q;

    logic [WIN_AW-1:0]    w0, w1, k, kprev;
    logic [5:0]           sh;
    logic [DATA_W-1:0]    mask64, hi_data;
    logic [2*DATA_W-1:0]  pair, wm128, wd128, merged, shifted;
    logic [DATA_W-1:0]    rd_ext;
    logic [SECT_W-1:0]    sect_idx;
    logic                 in_range, cmd_ok, map_hit;
    logic [31:0]          cmd;

    sbd_decode u_decode (
        .mode         (s_axis_tuser[0]),
        .offset       (s_axis_tdata[OFS_W-1:0]),
        .access_bytes (s_axis_tdata[OFS_W+SIZE_W-1:OFS_W]),
        .write_data   (s_axis_tdata[IN_TDATA_W-1:OFS_W+SIZE_W]),
        .req          (dec_req)
    );

    sbd_ram #(.WIDTH(DATA_W), .DEPTH(WIN_WORDS)) u_window (
        .clk   (clk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (win_wdata),
        .raddr (win_raddr),
        .rdata (win_q)
    );

    sbd_ram #(.WIDTH(DATA_W), .DEPTH(STORE_WORDS)) u_storage (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_q)
    );

    sbd_ram #(.WIDTH(64), .DEPTH(MAP_ROWS)) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_q)
    );

    always_comb
    begin
        w0       = req_reg.pos[POS_W-1:3];
        w1       = w0 + 1'b1;
        k        = cnt_reg[WIN_AW-1:0];
        kprev    = k - 1'b1;
        sh       = {req_reg.pos[2:0], 3'b000};
        for (int b = 0; b < 8; b++)
        begin
            mask64[b*8 +: 8] = {8{req_reg.bmask[b]}};
        end
        hi_data  = win_vld_reg[w1] ? win_q : '0;
        pair     = {hi_data, lo_reg};
        shifted  = pair >> sh;
        rd_ext   = shifted[DATA_W-1:0] & mask64;
        wm128    = {{DATA_W{1'b0}}, mask64} << sh;
        wd128    = {{DATA_W{1'b0}}, req_reg.wdata & mask64} << sh;
        merged   = (pair & ~wm128) | wd128;
        sect_idx = sector_reg[SECT_W-1:0];
        in_range = sector_reg < DATA_W'(SECTOR_COUNT);
        cmd      = req_reg.wdata[31:0];
        cmd_ok   = (cmd == CMD_LOAD_SECTOR) || (cmd == CMD_SAVE_SECTOR);
        map_hit  = map_q[sect_idx[5:0]];
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        sector_next    = sector_reg;
        err_next       = err_reg;
        win_vld_next   = win_vld_reg;
        cnt_next       = cnt_reg;
        clr_next       = clr_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        map_row_next   = map_row_reg;
        res_data_next  = res_data_reg;
        res_fault_next = res_fault_reg;
        out_vld_next   = out_vld_reg;
        out_data_next  = out_data_reg;
        out_fault_next = out_fault_reg;

        win_we    = 1'b0;
        win_waddr = w0;
        win_wdata = merged[DATA_W-1:0];
        win_raddr = w0;
        st_we     = 1'b0;
        st_waddr  = {sect_idx, kprev};
        st_wdata  = win_vld_reg[kprev] ? win_q : '0;
        st_raddr  = {sect_idx, k};
        map_we    = 1'b0;
        map_waddr = sect_idx[SECT_W-1:6];
        map_wdata = map_row_reg;
        map_raddr = sect_idx[SECT_W-1:6];

        if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            S_CLR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == MAP_AW'(MAP_ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_next   = dec_req;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_data_next  = '0;
                res_fault_next = 1'b0;
                state_next     = S_RESP;
                case (req_reg.kind)
                    K_RD_SECT: res_data_next = sector_reg;
                    K_RD_STAT: res_data_next = {{(DATA_W-1){1'b0}}, err_reg};
                    K_WR_SECT: sector_next = req_reg.wdata;
                    K_CMD:
                    begin
                        if (!in_range || !cmd_ok)
                            err_next = 1'b1;
                        else
                            state_next = S_MAP;
                    end
                    K_WIN_RD: state_next = S_W0;
                    K_WIN_WR: state_next = S_W0;
                    default:  res_fault_next = 1'b1;
                endcase
            end
            S_MAP:
            begin
                cnt_next = '0;
                if (cmd == CMD_LOAD_SECTOR)
                begin
                    if (map_hit)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        // A sector never saved reads as zeros.
                        win_vld_next = '0;
                        err_next     = 1'b0;
                        state_next   = S_RESP;
                    end
                end
                else
                begin
                    map_row_next = map_q | (64'd1 << sect_idx[5:0]);
                    state_next   = S_SAVE;
                end
            end
            S_LOAD:
            begin
                if (cnt_reg != '0)
                begin
                    win_we              = 1'b1;
                    win_waddr           = kprev;
                    win_wdata           = st_q;
                    win_vld_next[kprev] = 1'b1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (WIN_AW + 1)'(WIN_WORDS))
                begin
                    err_next   = 1'b0;
                    state_next = S_RESP;
                end
            end
            S_SAVE:
            begin
                win_raddr = k;
                if (cnt_reg != '0)
                begin
                    st_we = 1'b1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (WIN_AW + 1)'(WIN_WORDS))
                begin
                    map_we     = 1'b1;
                    err_next   = 1'b0;
                    state_next = S_RESP;
                end
            end
            S_W0:
            begin
                lo_next    = win_vld_reg[w0] ? win_q : '0;
                win_raddr  = w1;
                state_next = S_W1;
            end
            S_W1:
            begin
                if (req_reg.kind == K_WIN_RD)
                begin
                    res_data_next = rd_ext;
                    state_next    = S_RESP;
                end
                else
                begin
                    win_we           = 1'b1;
                    win_vld_next[w0] = 1'b1;
                    hi_next          = merged[2*DATA_W-1:DATA_W];
                    state_next       = req_reg.need_hi ? S_WHI : S_RESP;
                end
            end
            S_WHI:
            begin
                win_we           = 1'b1;
                win_waddr        = w1;
                win_wdata        = hi_reg;
                win_vld_next[w1] = 1'b1;
                state_next       = S_RESP;
            end
            S_RESP:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_vld_next   = 1'b1;
                    out_data_next  = res_data_reg;
                    out_fault_next = res_fault_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            sector_reg  <= '0;
            err_reg     <= 1'b0;
            win_vld_reg <= '0;
            cnt_reg     <= '0;
            clr_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sector_reg  <= sector_next;
            err_reg     <= err_next;
            win_vld_reg <= win_vld_next;
            cnt_reg     <= cnt_next;
            clr_reg     <= clr_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        map_row_reg   <= map_row_next;
        res_data_reg  <= res_data_next;
        res_fault_reg <= res_fault_next;
        out_data_reg  <= out_data_next;
        out_fault_reg <= out_fault_next;
    end

    assign s_axis_tready   = (state_reg == S_IDLE);
    assign m_axis_tvalid   = out_vld_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_fault_reg;

endmodule
